>>> design/reply_frame_scanner_core_defines.svh
// Assertion macros for the reply frame scanner core.
// Depends on a clock named aclk and an active-low reset named aresetn in scope.
`ifndef REPLY_FRAME_SCANNER_CORE_DEFINES_SVH
`define REPLY_FRAME_SCANNER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RFS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("reply frame scanner: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define RFS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("reply frame scanner: next-cycle check failed");

`endif

>>> design/rfs_pkg.sv
// Shared types and constants for the reply frame scanner.
// No dependencies; used by rfs_step and reply_frame_scanner_core.
package rfs_pkg;

    localparam int FRAME_BYTES = 8;
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam int LEN_W       = 4;
    localparam int SKIP_W      = 3;
    localparam int DATA_W      = FRAME_BYTES * 8;

    localparam logic [7:0]        TAIL_BYTE           = 8'h6B;
    localparam logic [7:0]        LONG_REPLY_FUNCTION = 8'h36;
    localparam logic [LEN_W-1:0]  MIN_LENGTH          = LEN_W'(3);
    localparam logic [LEN_W-1:0]  MAX_LENGTH          = LEN_W'(FRAME_BYTES);
    localparam logic [SKIP_W-1:0] LONG_SKIP           = SKIP_W'(8 - 2);
    localparam logic [SKIP_W-1:0] SHORT_SKIP          = SKIP_W'(4 - 2);

    typedef enum logic [1:0] {
        CFG_DEVICE_ADDRESS  = 2'd0,
        CFG_FUNC_CODE       = 2'd1,
        CFG_EXPECTED_LENGTH = 2'd2
    } cfg_index_t;

    typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

    typedef struct packed {
        logic [LEN_W-1:0]  pos;
        logic [SKIP_W-1:0] skip;
    } rfs_state_t;

    typedef struct packed {
        rfs_state_t       next;
        logic             store_we;
        logic [IDX_W-1:0] store_idx;
        logic             emit;
    } step_t;

endpackage

>>> design/rfs_step.sv
// Per-byte decision logic of the reply frame scanner: next state, store write, emit.
// Depends on rfs_pkg.
module rfs_step (
    input  rfs_pkg::rfs_state_t       state_in,
    input  rfs_pkg::frame_t           store,
    input  logic [7:0]                rx_byte,
    input  logic [7:0]                device_address,
    input  logic [7:0]                func_code,
    input  logic [rfs_pkg::LEN_W-1:0] expected_length,
    output rfs_pkg::step_t            step_out,
    output rfs_pkg::frame_t           frame_data
);

    logic                             len_ok;
    logic [rfs_pkg::LEN_W-1:0]        pos_inc;
    logic [rfs_pkg::IDX_W-1:0]        tail_idx;
    rfs_pkg::frame_t                  store_n;

    always_comb begin
        len_ok   = (expected_length >= rfs_pkg::MIN_LENGTH) &&
                   (expected_length <= rfs_pkg::MAX_LENGTH);
        pos_inc  = state_in.pos + rfs_pkg::LEN_W'(1);
        tail_idx = rfs_pkg::IDX_W'(expected_length - rfs_pkg::LEN_W'(1));
        store_n  = store;

        step_out.next      = state_in;
        step_out.store_we  = 1'b0;
        step_out.store_idx = state_in.pos[rfs_pkg::IDX_W-1:0];
        step_out.emit      = 1'b0;

        if (!len_ok) begin
            step_out.next = state_in;
        end else if (state_in.skip != '0) begin
            step_out.next.skip = state_in.skip - rfs_pkg::SKIP_W'(1);
        end else if (state_in.pos == '0) begin
            if (rx_byte == device_address) begin
                step_out.store_we = 1'b1;
                step_out.next.pos = rfs_pkg::LEN_W'(1);
            end
        end else if (state_in.pos == rfs_pkg::LEN_W'(1)) begin
            if (rx_byte != func_code) begin
                step_out.next.pos  = '0;
                step_out.next.skip = (rx_byte == rfs_pkg::LONG_REPLY_FUNCTION) ?
                                     rfs_pkg::LONG_SKIP : rfs_pkg::SHORT_SKIP;
            end else begin
                step_out.store_we = 1'b1;
                step_out.next.pos = rfs_pkg::LEN_W'(2);
            end
        end else begin
            if (state_in.pos < rfs_pkg::MAX_LENGTH) begin
                step_out.store_we = 1'b1;
                store_n[state_in.pos[rfs_pkg::IDX_W-1:0]] = rx_byte;
            end
            if ((pos_inc != '0) && (pos_inc < expected_length)) begin
                step_out.next.pos = pos_inc;
            end else begin
                step_out.next.pos = '0;
                step_out.emit     = (store_n[tail_idx] == rfs_pkg::TAIL_BYTE);
            end
        end

        for (int k = 0; k < rfs_pkg::FRAME_BYTES; k++) begin
            frame_data[k] = (rfs_pkg::LEN_W'(k) < expected_length) ? store_n[k] : 8'h00;
        end
    end

endmodule

>>> design/reply_frame_scanner_core.sv
// Reply frame scanner top level: config registers, scan state, frame store, result register.
// Depends on rfs_pkg, rfs_step and reply_frame_scanner_core_defines.svh.
//
// Usage:
//   Input channel s_valid/s_ready/s_rx_byte carries one received byte per transfer.
//   Result channel m_valid/m_ready/m_frame_data/m_frame_length carries one matched
//   frame per transfer; byte 0 sits in bits 7:0 and bytes past the length are zero.
//   Config port cfg_wr_en/cfg_index/cfg_wr_data writes device address, expected
//   function and expected length; write only while no result is pending.
//   A frame appears on m_valid in the cycle after the transfer of its last byte.
//   Throughput: one byte per cycle while s_ready is high; the byte decision logic
//   feeds the result register directly, with no register stage between them.
//   Reset (aresetn low, synchronous): registers return to address 0, function 0,
//   length 4; the scanner hunts for the address and drops any pending result.
//   Stall: a waiting result holds in the output register; s_ready stays high while
//   the result register is empty or being drained, and drops only when a result
//   waits and m_ready is low.
`include "reply_frame_scanner_core_defines.svh"

module reply_frame_scanner_core (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        cfg_wr_en,
    input  logic [1:0]                  cfg_index,
    input  logic [7:0]                  cfg_wr_data,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [7:0]                  s_rx_byte,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [rfs_pkg::DATA_W-1:0]  m_frame_data,
    output logic [rfs_pkg::LEN_W-1:0]   m_frame_length
);

    logic [7:0]                 dev_addr_reg;
    logic [7:0]                 exp_func_reg;
    logic [rfs_pkg::LEN_W-1:0]  exp_len_reg;

    rfs_pkg::rfs_state_t        state_reg;
    rfs_pkg::rfs_state_t        state_next;
    rfs_pkg::frame_t            store_reg;

    logic                       m_valid_reg;
    logic [rfs_pkg::DATA_W-1:0] m_frame_data_reg;
    logic [rfs_pkg::LEN_W-1:0]  m_frame_length_reg;

    rfs_pkg::step_t             step;
    rfs_pkg::frame_t            frame_data;
    logic                       accept;
    logic                       len_off;
    logic                       result_len_ok;

    rfs_step u_step (
        .state_in          (state_reg),
        .store             (store_reg),
        .rx_byte           (s_rx_byte),
        .device_address    (dev_addr_reg),
        .func_code         (exp_func_reg),
        .expected_length   (exp_len_reg),
        .step_out          (step),
        .frame_data        (frame_data)
    );

    assign s_ready    = !m_valid_reg || m_ready;
    assign accept     = s_valid && s_ready;
    assign state_next = accept ? step.next : state_reg;

    assign m_valid        = m_valid_reg;
    assign m_frame_data   = m_frame_data_reg;
    assign m_frame_length = m_frame_length_reg;

    assign len_off       = (exp_len_reg < rfs_pkg::MIN_LENGTH) ||
                           (exp_len_reg > rfs_pkg::MAX_LENGTH);
    assign result_len_ok = (m_frame_length_reg >= rfs_pkg::MIN_LENGTH) &&
                           (m_frame_length_reg <= rfs_pkg::MAX_LENGTH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg <= '0;
            exp_func_reg <= '0;
            exp_len_reg  <= rfs_pkg::LEN_W'(4);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rfs_pkg::CFG_DEVICE_ADDRESS:    dev_addr_reg <= cfg_wr_data;
                rfs_pkg::CFG_FUNC_CODE:         exp_func_reg <= cfg_wr_data;
                rfs_pkg::CFG_EXPECTED_LENGTH:   exp_len_reg  <= cfg_wr_data[rfs_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept && step.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && step.store_we) begin
            store_reg[step.store_idx] <= s_rx_byte;
        end
        if (accept && step.emit) begin
            m_frame_data_reg   <= frame_data;
            m_frame_length_reg <= exp_len_reg;
        end
    end

    `RFS_ASSERT_IMPL(a_pos_in_store, 1'b1, state_reg.pos < rfs_pkg::MAX_LENGTH)
    `RFS_ASSERT_IMPL(a_skip_while_hunting, state_reg.skip != '0, state_reg.pos == '0)
    `RFS_ASSERT_IMPL(a_result_length, m_valid_reg, result_len_ok)
    `RFS_ASSERT_NEXT(a_idle_when_disabled, accept && len_off, $stable(state_reg))

endmodule
